### rtl/bmhq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

  // request kind
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_POP_RD,
    ST_POP_LOAD,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

### rtl/bmhq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

### rtl/binary_min_heap_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Binary min-heap priority queue held in one RAM with two read ports.
// Request channel (req_valid/req_ready): kind 0 pushes key and payload,
// kind 1 pops the smallest entry. Result channel (res_valid/res_ready):
// one result item per request, carrying the root key and payload (zero when
// empty), the count, is_empty and a status (ok, push rejected full, pop on
// empty).
// A push writes its entry at the end and climbs level by level; a pop moves
// the last entry to the root and sifts it down. A rejected push, a pop on
// empty or a pop of the last entry skips the sift. Each heap level costs
// one RAM read and one compare with write-back, so the tree height bounds
// the work of an item. One item is worked on at a time.
// The next request is taken as soon as a result reaches the output
// register, even while that result waits for res_ready; if the receiver
// stalls, the following result holds in the sequencer until the register
// frees. Reset empties the queue at once; RAM contents are not cleared and
// read data is only used from slots that hold written entries.

module binary_min_heap_queue import bmhq_pkg::*; #(
  parameter int DEPTH        = 1024,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire logic                         kind,
  input  wire logic [KEY_BITS-1:0]          key,
  input  wire logic [PAYLOAD_BITS-1:0]      payload,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output logic      [KEY_BITS-1:0]          top_key,
  output logic      [PAYLOAD_BITS-1:0]      top_payload,
  output logic      [$clog2(DEPTH+1)-1:0]   count,
  output logic                              is_empty,
  output logic      [1:0]                   status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = KEY_BITS + PAYLOAD_BITS;

  state_t                  state, state_next;
  logic [CW-1:0]           entry_count, entry_count_next;
  logic [AW-1:0]           pos, pos_next;
  logic [EW-1:0]           cur, cur_next;
  status_t                 op_status, op_status_next;
  logic [KEY_BITS-1:0]     root_key;
  logic [PAYLOAD_BITS-1:0] root_pay;

  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [EW-1:0] wdata, rd_a, rd_b;

  logic [AW-1:0]       parent;
  logic [AW+1:0]       child_l, child_r, cnt_ext;
  logic                l_ok, r_ok, take_l, take_r;
  logic [KEY_BITS-1:0] cur_key, key_a, key_b, pick_key;
  logic                load_res;

  bmhq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  assign cur_key = cur[EW-1:PAYLOAD_BITS];
  assign key_a   = rd_a[EW-1:PAYLOAD_BITS];
  assign key_b   = rd_b[EW-1:PAYLOAD_BITS];
  assign parent  = AW'((pos - AW'(1)) >> 1);
  assign child_l = {1'b0, pos, 1'b1};
  assign child_r = child_l + (AW+2)'(1);
  assign cnt_ext = (AW+2)'(entry_count);
  assign l_ok    = child_l < cnt_ext;
  assign r_ok    = child_r < cnt_ext;
  // Ties move: a child equal to the current pick wins.
  assign take_l   = l_ok && (key_a <= cur_key);
  assign pick_key = take_l ? key_a : cur_key;
  assign take_r   = r_ok && (key_b <= pick_key);

  assign req_ready = (state == ST_IDLE);
  assign load_res  = (state == ST_FINISH) && (!res_valid || res_ready);

  // The moving entry lives in cur; the RAM slot at pos is a hole until the
  // sift ends. Reads always target a different level than the pending write,
  // so no forwarding is needed.
  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    pos_next         = pos;
    cur_next         = cur;
    op_status_next   = op_status;
    we               = 1'b0;
    waddr            = pos;
    wdata            = cur;
    raddr_a          = parent;
    raddr_b          = AW'(child_r);
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          op_status_next = STATUS_OK;
          if (kind == OP_PUSH) begin
            if (entry_count >= CW'(DEPTH)) begin
              op_status_next = STATUS_FULL;
              state_next     = ST_FINISH;
            end else begin
              cur_next         = {key, payload};
              pos_next         = AW'(entry_count);
              entry_count_next = entry_count + CW'(1);
              state_next       = ST_UP_RD;
            end
          end else begin
            if (entry_count == '0) begin
              op_status_next = STATUS_EMPTY;
              state_next     = ST_FINISH;
            end else begin
              entry_count_next = entry_count - CW'(1);
              pos_next         = '0;
              state_next       = (entry_count == CW'(1)) ? ST_FINISH : ST_POP_RD;
            end
          end
        end
      end
      ST_UP_RD: begin
        if (pos == '0) begin
          we         = 1'b1;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (cur_key <= key_a) begin
          wdata      = rd_a;
          pos_next   = parent;
          state_next = ST_UP_RD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_POP_RD: begin
        // count already holds the index of the last entry
        raddr_a    = AW'(entry_count);
        state_next = ST_POP_LOAD;
      end
      ST_POP_LOAD: begin
        cur_next   = rd_a;
        state_next = ST_DN_RD;
      end
      ST_DN_RD: begin
        raddr_a = AW'(child_l);
        if (!l_ok) begin
          we         = 1'b1;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wdata      = rd_b;
          pos_next   = AW'(child_r);
          state_next = ST_DN_RD;
        end else if (take_l) begin
          wdata      = rd_a;
          pos_next   = AW'(child_l);
          state_next = ST_DN_RD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!res_valid || res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos       <= pos_next;
    cur       <= cur_next;
    op_status <= op_status_next;
    // mirror the root slot so the result needs no extra read
    if (we && (waddr == '0)) begin
      root_key <= wdata[EW-1:PAYLOAD_BITS];
      root_pay <= wdata[PAYLOAD_BITS-1:0];
    end
    if (load_res) begin
      count    <= entry_count;
      status   <= op_status;
      is_empty <= (entry_count == '0);
      if (entry_count == '0) begin
        top_key     <= '0;
        top_payload <= '0;
      end else begin
        top_key     <= root_key;
        top_payload <= root_pay;
      end
    end
  end

  a_write_below_count: assert property (@(posedge clk) disable iff (rst)
    we |-> ((AW+1)'(waddr) < (AW+1)'(entry_count)))
    else $error("heap write outside the held entries");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && is_empty) |-> (top_key == '0 && top_payload == '0 && count == '0))
    else $error("empty result with non-zero fields");

  a_pop_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (kind == OP_POP) && entry_count == '0) |=>
      (op_status == STATUS_EMPTY && state == ST_FINISH))
    else $error("pop on empty heap not flagged");

endmodule

`default_nettype wire

### bench/binary_min_heap_queue_tb.sv
`timescale 1ns / 1ps

module binary_min_heap_queue_tb;
  import bmhq_pkg::*;

  localparam int HEAP_DEPTH   = 1024;
  localparam int KEY_W        = 32;
  localparam int PAY_W        = 16;
  localparam int COUNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int MAX_GAP      = 40;
  localparam int SETTLE_CYCLES = 40;
  localparam int PRINT_LIMIT  = 20;

  typedef struct {
    logic [KEY_W-1:0]   top_key;
    logic [PAY_W-1:0]   top_payload;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    status_t            status;
  } heap_view_t;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_ready;
  logic               kind;
  logic [KEY_W-1:0]   key;
  logic [PAY_W-1:0]   payload;
  logic               res_valid;
  logic               res_ready;
  logic [KEY_W-1:0]   top_key;
  logic [PAY_W-1:0]   top_payload;
  logic [COUNT_W-1:0] count;
  logic               is_empty;
  logic [1:0]         status;

  // shadow heap, kept in step with every accepted item
  logic [KEY_W-1:0]   shadow_keys [HEAP_DEPTH];
  logic [PAY_W-1:0]   shadow_pays [HEAP_DEPTH];
  int                 shadow_count;

  heap_view_t         due_views[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int error_count;
  int views_checked;
  int pushes_ok;
  int pushes_full;
  int pops_ok;
  int pops_empty;
  int peak_count;

  binary_min_heap_queue #(
    .DEPTH       (HEAP_DEPTH),
    .KEY_BITS    (KEY_W),
    .PAYLOAD_BITS(PAY_W)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .kind       (kind),
    .key        (key),
    .payload    (payload),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .top_key    (top_key),
    .top_payload(top_payload),
    .count      (count),
    .is_empty   (is_empty),
    .status     (status)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic void swap_shadow(input int a, input int b);
    logic [KEY_W-1:0] k;
    logic [PAY_W-1:0] p;
    k = shadow_keys[a];
    p = shadow_pays[a];
    shadow_keys[a] = shadow_keys[b];
    shadow_pays[a] = shadow_pays[b];
    shadow_keys[b] = k;
    shadow_pays[b] = p;
  endfunction

  function automatic heap_view_t predict_heap_op(input logic op, input logic [KEY_W-1:0] k,
                                                 input logic [PAY_W-1:0] p);
    heap_view_t v;
    int pos;
    int up;
    int lc;
    int rc;
    int pick;
    v.status = STATUS_OK;
    if (op == OP_PUSH) begin
      if (shadow_count >= HEAP_DEPTH) begin
        v.status = STATUS_FULL;
        pushes_full++;
      end else begin
        pos = shadow_count;
        shadow_keys[pos] = k;
        shadow_pays[pos] = p;
        shadow_count++;
        pushes_ok++;
        // ties climb: swap while at most the parent
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (shadow_keys[pos] <= shadow_keys[up]) begin
            swap_shadow(pos, up);
            pos = up;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (shadow_count == 0) begin
        v.status = STATUS_EMPTY;
        pops_empty++;
      end else begin
        pops_ok++;
        swap_shadow(0, shadow_count - 1);
        shadow_count--;
        pos = 0;
        while (pos < shadow_count) begin
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          pick = pos;
          if (lc < shadow_count && shadow_keys[lc] <= shadow_keys[pick]) pick = lc;
          if (rc < shadow_count && shadow_keys[rc] <= shadow_keys[pick]) pick = rc;
          if (pick == pos) break;
          swap_shadow(pos, pick);
          pos = pick;
        end
      end
    end
    if (shadow_count > peak_count) peak_count = shadow_count;
    if (shadow_count > 0) begin
      v.top_key     = shadow_keys[0];
      v.top_payload = shadow_pays[0];
      v.is_empty    = 1'b0;
    end else begin
      v.top_key     = '0;
      v.top_payload = '0;
      v.is_empty    = 1'b1;
    end
    v.count = COUNT_W'(shadow_count);
    return v;
  endfunction

  // small keys make ties common; extremes hit the compare edges
  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return KEY_W'($urandom_range(0, 7));
    if (sel == 3) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return KEY_W'($urandom);
  endfunction

  // called at a rising edge; returns at the edge that took the item
  task automatic send_request(input logic op, input logic [KEY_W-1:0] k,
                              input logic [PAY_W-1:0] p);
    int gap;
    logic ready_seen;
    heap_view_t due;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    kind      <= op;
    key       <= k;
    payload   <= p;
    do begin
      @(negedge clk);
      ready_seen = req_ready;
      @(posedge clk);
    end while (!ready_seen);
    due = predict_heap_op(op, k, p);
    due_views = {due_views, due};
  endtask

  task automatic send_random(input int push_pct);
    logic op;
    op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
    send_request(op, pick_key(), PAY_W'($urandom_range(0, 65535)));
  endtask

  task automatic wait_views_drained();
    req_valid <= 1'b0;
    while (due_views.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(OP_POP, '1, '1);
    send_request(OP_PUSH, '1, 16'hffff);
    send_request(OP_PUSH, '0, 16'h0000);
    send_request(OP_PUSH, '1, 16'haaaa);
    send_request(OP_PUSH, 32'd5, 16'h0001);
    send_request(OP_PUSH, 32'd5, 16'h0002);
    send_request(OP_PUSH, 32'd5, 16'h0003);
    send_request(OP_PUSH, '0, 16'hffff);
    send_request(OP_PUSH, 32'h8000_0000, 16'h5555);
    repeat (8) send_request(OP_POP, 32'h1234_5678, 16'h9abc);
    send_request(OP_POP, '0, '0);
    send_request(OP_PUSH, 32'h7fff_ffff, 16'h8000);
    send_request(OP_POP, '0, '0);
    wait_views_drained();
  endtask

  task automatic test_random_traffic(input int items, input int push_pct,
                                     input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) send_random(push_pct);
    wait_views_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // hold the result side long enough for the input to stall
    hold_cycles = 300;
    repeat (40) send_random(60);
    wait_views_drained();
  endtask

  task automatic test_fill_to_capacity();
    send_idle_pct  = 18;
    recv_stall_pct = 18;
    while (shadow_count < HEAP_DEPTH) send_random(90);
    repeat (6) send_random(100);
    repeat (60) send_random(50);
    wait_views_drained();
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      res_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // sample between edges; the item moves at the next rising edge
  always @(negedge clk) begin : check_views
    heap_view_t want;
    if (!rst && res_valid && res_ready) begin
      if (due_views.size() == 0) begin
        report_mismatch($sformatf("result with nothing due, top_key %0h count %0d",
                                  top_key, count));
      end else begin
        want = due_views.pop_front();
        views_checked++;
        if (top_key !== want.top_key)
          report_mismatch($sformatf("top_key got %0h expected %0h", top_key, want.top_key));
        if (top_payload !== want.top_payload)
          report_mismatch($sformatf("top_payload got %0h expected %0h",
                                    top_payload, want.top_payload));
        if (count !== want.count)
          report_mismatch($sformatf("count got %0d expected %0d", count, want.count));
        if (is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty got %0b expected %0b", is_empty, want.is_empty));
        if (status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d", status, want.status));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    req_valid      = 1'b0;
    kind           = OP_PUSH;
    key            = '0;
    payload        = '0;
    shadow_count   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    error_count    = 0;
    views_checked  = 0;
    pushes_ok      = 0;
    pushes_full    = 0;
    pops_ok        = 0;
    pops_empty     = 0;
    peak_count     = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic(100, 55, 0, 0);
    test_random_traffic(100, 55, 65, 0);
    test_random_traffic(100, 50, 0, 65);
    test_random_traffic(100, 60, 18, 18);
    test_backpressure();
    test_fill_to_capacity();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_views.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_views.size()));
    $display("covered %0d pushes stored, %0d pushes refused when full, %0d pops, %0d pops on empty",
             pushes_ok, pushes_full, pops_ok, pops_empty);
    $display("checked %0d results, heap peaked at %0d entries, %0d mismatches",
             views_checked, peak_count, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/binary_min_heap_queue.sv
bench/binary_min_heap_queue_tb.sv
